// File: src/mqsb_pkg.sv
`default_nettype none

package mqsb_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int STAT_W = 2;

  // operation codes carried in func
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic signed [DATA_W-1:0] UNDERFLOW_DATA = -32'sd1;

endpackage

`default_nettype wire

// File: src/mqsb_in_if.sv
`default_nettype none

interface mqsb_in_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, func, queue_id, push_value, input ready);
  modport sink   (input valid, func, queue_id, push_value, output ready);
endinterface

`default_nettype wire

// File: src/mqsb_out_if.sv
`default_nettype none

interface mqsb_out_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, pop_value, status, input ready);
  modport sink   (input valid, pop_value, status, output ready);
endinterface

`default_nettype wire

// File: src/mqsb_ptr_ram.sv
`default_nettype none

module mqsb_ptr_ram #(
  parameter int NUM_QUEUES = 4,
  parameter int QW         = 2,
  parameter int PW         = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [QW-1:0] rd_idx,
  output logic      [PW-1:0] rd_head,
  output logic      [PW-1:0] rd_tail,
  input  wire logic          wr_en,
  input  wire logic [QW-1:0] wr_idx,
  input  wire logic [PW-1:0] wr_head,
  input  wire logic [PW-1:0] wr_tail
);
  import mqsb_pkg::*;

  logic [2*PW-1:0]       mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_r;
  logic [2*PW-1:0]       rd_word_r;
  logic                  rd_vld_r;

  // valid bits stand in for the all-zero pointer reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_head, wr_tail};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_idx];
      rd_vld_r  <= vld_r[rd_idx];
    end
  end

  assign rd_head = rd_vld_r ? rd_word_r[2*PW-1:PW] : '0;
  assign rd_tail = rd_vld_r ? rd_word_r[PW-1:0]    : '0;

endmodule

`default_nettype wire

// File: src/mqsb_slot_ram.sv
`default_nettype none

module mqsb_slot_ram #(
  parameter int SLOTS = 64,
  parameter int AW    = 6
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic signed [mqsb_pkg::DATA_W-1:0] wr_data,
  input  wire logic                            rd_en,
  input  wire logic [AW-1:0]                   rd_addr,
  output logic signed [mqsb_pkg::DATA_W-1:0]      rd_data
);
  import mqsb_pkg::*;

  logic signed [DATA_W-1:0] mem [SLOTS];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/multi_queue_shared_buffer_top.sv
// Several linear queues sharing one slot memory; queue q owns the slots
// from q * QUEUE_DEPTH upward. Head and tail pointers live in a small
// pointer memory, the values in the slot memory.
// in_chan: one transaction per operation (func 0 enqueue, 1 dequeue,
// queue_id, push_value). out_chan: exactly one result per operation, in
// order, carrying pop_value and status (ok, overflow, underflow).
// Each operation is worked in steps: it reads its queue's pointers, then
// updates them and accesses the slot memory, then takes the slot read data
// into the output register. That read-modify-write of the pointer entry is
// done before the next operation reads the pointers, so one operation is
// worked on at a time and in_chan takes a new transaction only once the
// previous one has put its result into the output register.
// The output register holds a finished result while out_chan stalls; a new
// operation is still accepted and runs up to the point where its result
// needs the output register, where it waits.
// Reset (rst_n low, synchronous) empties every queue and drops any result
// in flight; slot contents are not cleared and need no clearing pass.
`default_nettype none

module multi_queue_shared_buffer_top #(
  parameter int NUM_QUEUES  = mqsb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqsb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mqsb_in_if.sink   in_chan,
  mqsb_out_if.source out_chan
);
  import mqsb_pkg::*;

  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [6:0]    NQ_LIM = 7'(NUM_QUEUES);
  localparam logic [PW-1:0] QD_LIM = PW'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_SLOT = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic                     op_func_r;
  logic [QID_W-1:0]         op_qid_r;
  logic signed [DATA_W-1:0] op_value_r;
  logic [STAT_W-1:0]        op_status_r, op_status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;

  logic          in_fire, out_free;
  logic [PW-1:0] cur_head, cur_tail;
  logic          q_ok, enq_ok, deq_ok;
  logic [QW-1:0] op_idx;
  logic [AW-1:0] slot_base, slot_addr;
  logic          ptr_wr_en, slot_wr_en, slot_rd_en;
  logic [PW-1:0] new_head, new_tail;
  logic signed [DATA_W-1:0] slot_rd_data;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign op_idx    = QW'(op_qid_r);
  assign q_ok      = {5'b0, op_qid_r} < NQ_LIM;
  assign enq_ok    = q_ok && (cur_tail < QD_LIM);
  assign deq_ok    = q_ok && (cur_head < cur_tail);
  assign slot_base = AW'(op_idx) * AW'(QUEUE_DEPTH);

  always_comb begin
    slot_addr = slot_base + AW'(op_func_r == FUNC_DEQ ? cur_head : cur_tail);
  end

  mqsb_ptr_ram #(
    .NUM_QUEUES(NUM_QUEUES),
    .QW        (QW),
    .PW        (PW)
  ) u_ptr_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_idx (QW'(in_chan.queue_id)),
    .rd_head(cur_head),
    .rd_tail(cur_tail),
    .wr_en  (ptr_wr_en),
    .wr_idx (op_idx),
    .wr_head(new_head),
    .wr_tail(new_tail)
  );

  mqsb_slot_ram #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (slot_wr_en),
    .wr_addr(slot_addr),
    .wr_data(op_value_r),
    .rd_en  (slot_rd_en),
    .rd_addr(slot_addr),
    .rd_data(slot_rd_data)
  );

  // pointer update and slot access in the cycle after the pointer read
  always_comb begin
    ptr_wr_en     = 1'b0;
    slot_wr_en    = 1'b0;
    slot_rd_en    = 1'b0;
    new_head      = cur_head;
    new_tail      = cur_tail;
    op_status_nxt = op_status_r;
    if (state_r == S_PTR) begin
      if (op_func_r == FUNC_ENQ) begin
        if (enq_ok) begin
          ptr_wr_en     = 1'b1;
          slot_wr_en    = 1'b1;
          new_tail      = cur_tail + PW'(1);
          op_status_nxt = ST_OK;
        end else begin
          op_status_nxt = ST_OVERFLOW;
        end
      end else begin
        if (deq_ok) begin
          ptr_wr_en     = 1'b1;
          slot_rd_en    = 1'b1;
          new_head      = cur_head + PW'(1);
          op_status_nxt = ST_OK;
        end else begin
          op_status_nxt = ST_UNDERFLOW;
        end
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_PTR;
        end
      end
      S_PTR: begin
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = op_status_r;
          if (op_func_r == FUNC_ENQ) begin
            out_data_nxt = '0;
          end else if (op_status_r == ST_OK) begin
            out_data_nxt = slot_rd_data;
          end else begin
            out_data_nxt = UNDERFLOW_DATA;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_func_r  <= in_chan.func;
      op_qid_r   <= in_chan.queue_id;
      op_value_r <= in_chan.push_value;
    end
    op_status_r  <= op_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pop_value = out_data_r;
  assign out_chan.status    = out_status_r;

  // underflow always carries the all-ones marker
  a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_UNDERFLOW) |-> (out_data_r == UNDERFLOW_DATA))
    else $error("underflow result without -1 data");

  // overflow only comes from an enqueue, whose data is zero
  a_overflow_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OVERFLOW) |-> (out_data_r == '0))
    else $error("overflow result with nonzero data");

  // slot memory is written only by an enqueue and read only by a dequeue
  a_slot_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!slot_wr_en || op_func_r == FUNC_ENQ) && (!slot_rd_en || op_func_r == FUNC_DEQ))
    else $error("slot access does not match operation");

  // a finished operation lands in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

// File: bench/mqsb_result_checker.sv
`default_nettype none

module mqsb_result_checker #(
  parameter int NUM_QUEUES  = mqsb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqsb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mqsb_in_if        in_mon,
  mqsb_out_if       out_mon,
  output int        fail_count,
  output int        results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import mqsb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
  } pop_result_t;

  logic signed [DATA_W-1:0] slot_mem [NUM_QUEUES*QUEUE_DEPTH];
  logic [PTR_W-1:0]         head_ptr [NUM_QUEUES];
  logic [PTR_W-1:0]         tail_ptr [NUM_QUEUES];
  pop_result_t              pending_results [$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  // linear queues: pointers only climb, a full queue stays full
  function automatic pop_result_t apply_queue_op(input logic f,
                                                 input logic [QID_W-1:0] q,
                                                 input logic signed [DATA_W-1:0] v);
    pop_result_t r;
    int          base;
    base = int'(q) * QUEUE_DEPTH;
    if (f == FUNC_ENQ) begin
      r.pop_value = '0;
      if (int'(q) < NUM_QUEUES && int'(tail_ptr[q]) < QUEUE_DEPTH) begin
        slot_mem[base + int'(tail_ptr[q])] = v;
        tail_ptr[q] = tail_ptr[q] + 1'b1;
        r.status = ST_OK;
      end else begin
        r.status = ST_OVERFLOW;
      end
    end else begin
      if (int'(q) < NUM_QUEUES && head_ptr[q] < tail_ptr[q]) begin
        r.pop_value = slot_mem[base + int'(head_ptr[q])];
        head_ptr[q] = head_ptr[q] + 1'b1;
        r.status = ST_OK;
      end else begin
        r.pop_value = UNDERFLOW_DATA;
        r.status = ST_UNDERFLOW;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pop_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_queue_op(in_mon.func, in_mon.queue_id,
                                                 in_mon.push_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX)
            $display("%t: unexpected result transaction pop_value=%h status=%0d",
                     $realtime, out_mon.pop_value, out_mon.status);
        end else begin
          want = pending_results.pop_front();
          if (out_mon.pop_value !== want.pop_value || out_mon.status !== want.status) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_MAX)
              $display("%t: result mismatch pop_value exp %h got %h, status exp %0d got %0d",
                       $realtime, want.pop_value, out_mon.pop_value,
                       want.status, out_mon.status);
          end
        end
      end
    end
    results_due = pending_results.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mqsb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;      // no idling on either side once set
  logic hold_req = 1'b0;  // asks the receiver for one long stall
  int   fail_count;
  int   results_due;
  int   cycle_cnt = 0;

  mqsb_in_if  in_chan ();
  mqsb_out_if out_chan ();

  multi_queue_shared_buffer_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mqsb_result_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** multi_queue_shared_buffer_top: FAILED **");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    out_chan.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(input logic f, input logic [QID_W-1:0] q,
                         input logic signed [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.func       <= f;
    in_chan.queue_id   <= q;
    in_chan.push_value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return UNDERFLOW_DATA;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ops(input int count, input int enq_pct,
                            input int hold_at, input int calm_at);
    logic f;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (n == calm_at) calm = 1'b1;
      f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      send_op(f, QID_W'($urandom_range(0, NUM_QUEUES_DEF - 1)), pick_value());
    end
  endtask

  initial begin : op_source
    in_chan.valid      = 1'b0;
    in_chan.func       = FUNC_ENQ;
    in_chan.queue_id   = '0;
    in_chan.push_value = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, extremes, stored all-ones vs underflow, ignored payload on dequeue
    send_op(FUNC_DEQ, 2'd0, 32'sh0000_0000);
    send_op(FUNC_ENQ, 2'd0, 32'sh7FFF_FFFF);
    send_op(FUNC_ENQ, 2'd0, 32'sh8000_0000);
    send_op(FUNC_ENQ, 2'd1, 32'sh0000_0000);
    send_op(FUNC_ENQ, 2'd2, UNDERFLOW_DATA);
    send_op(FUNC_ENQ, 2'd3, 32'sh5555_5555);
    send_op(FUNC_DEQ, 2'd2, 32'sh1234_5678);
    send_op(FUNC_DEQ, 2'd2, 32'sh0000_0000);
    send_op(FUNC_DEQ, 2'd0, UNDERFLOW_DATA);
    send_op(FUNC_DEQ, 2'd0, 32'sh0000_0000);
    send_op(FUNC_DEQ, 2'd0, 32'sh0000_0000);
    send_op(FUNC_ENQ, 2'd1, 32'shAAAA_AAAA);
    send_op(FUNC_DEQ, 2'd1, 32'sh7FFF_FFFF);
    send_op(FUNC_DEQ, 2'd1, 32'sh8000_0000);
    send_op(FUNC_DEQ, 2'd3, 32'shAAAA_AAAA);
    send_op(FUNC_DEQ, 2'd3, UNDERFLOW_DATA);
    wait_drained();

    // enqueue-heavy so every queue fills up and then overflows
    random_ops(350, 60, 100, -1);
    wait_drained();
    random_ops(580, 45, -1, 480);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0)
      $display("** multi_queue_shared_buffer_top: PASSED **");
    else
      $display("** multi_queue_shared_buffer_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// File: multi_queue_shared_buffer_top.f
src/mqsb_pkg.sv
src/mqsb_in_if.sv
src/mqsb_out_if.sv
src/mqsb_ptr_ram.sv
src/mqsb_slot_ram.sv
src/multi_queue_shared_buffer_top.sv
bench/mqsb_result_checker.sv
bench/tb_top.sv
